### src/hrhp_pkg.sv
package hrhp_pkg;

  localparam int OffsetWidthDefault = 16;
  localparam int BodyStartWidth = 16;
  localparam int IndexWidth = 4;

  // Fields of one input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hrhp_req_t;

  // Fields of one result word.
  typedef struct packed {
    logic [7:0]                echo_byte;
    logic [2:0]                byte_class;
    logic [1:0]                line_event;
    logic                      final_flag;
    logic                      parse_ok;
    logic                      conn_persist;
    logic [BodyStartWidth-1:0] body_start;
  } hrhp_res_t;

  typedef enum logic [3:0] {
    PH_METHOD     = 4'd0,
    PH_PATH       = 4'd1,
    PH_VERSION    = 4'd2,
    PH_RL_CR      = 4'd3,
    PH_NAME       = 4'd4,
    PH_VALUE      = 4'd5,
    PH_CR_BLANK   = 4'd6,
    PH_CR_NOCOLON = 4'd7,
    PH_CR_COLON   = 4'd8,
    PH_BODY       = 4'd9,
    PH_FAILED     = 4'd10
  } hrhp_phase_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } hrhp_order_t;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_CLOSE = 2'd1,
    VERDICT_ALIVE = 2'd2,
    VERDICT_OTHER = 2'd3
  } hrhp_verdict_t;

  localparam logic [2:0] CLASS_METHOD = 3'd0;
  localparam logic [2:0] CLASS_PATH   = 3'd1;
  localparam logic [2:0] CLASS_VER    = 3'd2;
  localparam logic [2:0] CLASS_SEP    = 3'd3;
  localparam logic [2:0] CLASS_NAME   = 3'd4;
  localparam logic [2:0] CLASS_VALUE  = 3'd5;
  localparam logic [2:0] CLASS_BODY   = 3'd6;
  localparam logic [2:0] CLASS_IGNORE = 3'd7;

  localparam logic [1:0] EVENT_NONE    = 2'd0;
  localparam logic [1:0] EVENT_KEPT    = 2'd1;
  localparam logic [1:0] EVENT_DROPPED = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SP    = 8'h20;

  localparam logic [IndexWidth-1:0] VER_LEN   = 4'd8;
  localparam logic [IndexWidth-1:0] CONN_LEN  = 4'd10;
  localparam logic [IndexWidth-1:0] CLOSE_LEN = 4'd5;
  localparam logic [IndexWidth-1:0] ALIVE_LEN = 4'd10;

  // "HTTP/1.1"
  function automatic logic [7:0] ver_char(input logic [IndexWidth-1:0] idx);
    case (idx)
      4'd0: return 8'h48;
      4'd1: return 8'h54;
      4'd2: return 8'h54;
      4'd3: return 8'h50;
      4'd4: return 8'h2F;
      4'd5: return 8'h31;
      4'd6: return 8'h2E;
      4'd7: return 8'h31;
      default: return 8'h00;
    endcase
  endfunction

  // "Connection"
  function automatic logic [7:0] conn_char(input logic [IndexWidth-1:0] idx);
    case (idx)
      4'd0: return 8'h43;
      4'd1: return 8'h6F;
      4'd2: return 8'h6E;
      4'd3: return 8'h6E;
      4'd4: return 8'h65;
      4'd5: return 8'h63;
      4'd6: return 8'h74;
      4'd7: return 8'h69;
      4'd8: return 8'h6F;
      4'd9: return 8'h6E;
      default: return 8'h00;
    endcase
  endfunction

  // "close"
  function automatic logic [7:0] close_char(input logic [IndexWidth-1:0] idx);
    case (idx)
      4'd0: return 8'h63;
      4'd1: return 8'h6C;
      4'd2: return 8'h6F;
      4'd3: return 8'h73;
      4'd4: return 8'h65;
      default: return 8'h00;
    endcase
  endfunction

  // "keep-alive"
  function automatic logic [7:0] alive_char(input logic [IndexWidth-1:0] idx);
    case (idx)
      4'd0: return 8'h6B;
      4'd1: return 8'h65;
      4'd2: return 8'h65;
      4'd3: return 8'h70;
      4'd4: return 8'h2D;
      4'd5: return 8'h61;
      4'd6: return 8'h6C;
      4'd7: return 8'h69;
      4'd8: return 8'h76;
      4'd9: return 8'h65;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [IndexWidth-1:0] idx_inc(input logic [IndexWidth-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

### src/hrhp_parser.sv
module hrhp_parser
  import hrhp_pkg::*;
#(
  parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  hrhp_req_t step_in,
  output hrhp_res_t step_out
);

  localparam int ExtWidth = (OFFSET_WIDTH > BodyStartWidth) ? OFFSET_WIDTH : BodyStartWidth;

  hrhp_phase_t             phase, phase_next;
  logic [IndexWidth-1:0]   version_index, version_index_next;
  hrhp_order_t             version_order, version_order_next;
  logic [IndexWidth-1:0]   name_idx, name_idx_next;
  logic                    name_good, name_good_next;
  logic [IndexWidth-1:0]   value_idx, value_idx_next;
  logic                    close_good, close_good_next;
  logic                    alive_good, alive_good_next;
  logic                    conn_seen, conn_seen_next;
  hrhp_verdict_t           verdict, verdict_next;
  logic [OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_WIDTH-1:0] line_start, line_start_next;
  logic [OFFSET_WIDTH-1:0] body_offset, body_offset_next;

  logic [7:0]              b;
  logic [OFFSET_WIDTH-1:0] offset_inc;
  logic [OFFSET_WIDTH-1:0] start_sel;
  logic [ExtWidth-1:0]     start_ext;
  logic                    ok;
  logic                    keep;

  assign b = step_in.data_byte;
  assign offset_inc = (byte_offset == '1) ? byte_offset : byte_offset + 1'b1;

  always_comb begin
    phase_next         = phase;
    version_index_next = version_index;
    version_order_next = version_order;
    name_idx_next      = name_idx;
    name_good_next     = name_good;
    value_idx_next     = value_idx;
    close_good_next    = close_good;
    alive_good_next    = alive_good;
    conn_seen_next     = conn_seen;
    verdict_next       = verdict;
    byte_offset_next   = offset_inc;
    line_start_next    = line_start;
    body_offset_next   = body_offset;

    step_out.echo_byte  = b;
    step_out.byte_class = CLASS_IGNORE;
    step_out.line_event = EVENT_NONE;

    case (phase)
      PH_METHOD, PH_PATH: begin
        if (b == CHAR_CR) begin
          step_out.byte_class = CLASS_SEP;
          phase_next = PH_FAILED;
        end else if (b == CHAR_SP) begin
          step_out.byte_class = CLASS_SEP;
          phase_next = (phase == PH_METHOD) ? PH_PATH : PH_VERSION;
        end else begin
          step_out.byte_class = (phase == PH_METHOD) ? CLASS_METHOD : CLASS_PATH;
        end
      end
      PH_VERSION: begin
        if (b == CHAR_CR) begin
          step_out.byte_class = CLASS_SEP;
          phase_next = PH_RL_CR;
        end else begin
          step_out.byte_class = CLASS_VER;
          if (version_order == ORD_EQUAL) begin
            if (version_index >= VER_LEN) begin
              version_order_next = ORD_GREATER;
            end else if (b < ver_char(version_index)) begin
              version_order_next = ORD_LESS;
            end else if (b > ver_char(version_index)) begin
              version_order_next = ORD_GREATER;
            end
          end
          version_index_next = idx_inc(version_index);
        end
      end
      PH_RL_CR: begin
        if (b == CHAR_LF) begin
          step_out.byte_class = CLASS_SEP;
          phase_next      = PH_NAME;
          name_idx_next   = '0;
          name_good_next  = 1'b1;
          line_start_next = offset_inc;
        end else begin
          phase_next = PH_FAILED;
        end
      end
      PH_NAME: begin
        if (b == CHAR_CR) begin
          step_out.byte_class = CLASS_SEP;
          phase_next = (name_idx == '0) ? PH_CR_BLANK : PH_CR_NOCOLON;
        end else if (b == CHAR_COLON) begin
          step_out.byte_class = CLASS_SEP;
          name_good_next  = name_good && (name_idx == CONN_LEN);
          phase_next      = PH_VALUE;
          value_idx_next  = '0;
          close_good_next = 1'b1;
          alive_good_next = 1'b1;
        end else begin
          step_out.byte_class = CLASS_NAME;
          if (name_idx >= CONN_LEN || b != conn_char(name_idx)) begin
            name_good_next = 1'b0;
          end
          name_idx_next = idx_inc(name_idx);
        end
      end
      PH_VALUE: begin
        if (b == CHAR_CR) begin
          step_out.byte_class = CLASS_SEP;
          phase_next = PH_CR_COLON;
        end else begin
          step_out.byte_class = CLASS_VALUE;
          // Blanks ahead of the value are tagged but not matched.
          if (!(value_idx == '0 && (b == CHAR_SP || b == CHAR_TAB))) begin
            if (value_idx >= CLOSE_LEN || b != close_char(value_idx)) begin
              close_good_next = 1'b0;
            end
            if (value_idx >= ALIVE_LEN || b != alive_char(value_idx)) begin
              alive_good_next = 1'b0;
            end
            value_idx_next = idx_inc(value_idx);
          end
        end
      end
      PH_CR_BLANK, PH_CR_NOCOLON, PH_CR_COLON: begin
        if (b == CHAR_LF) begin
          step_out.byte_class = CLASS_SEP;
          if (phase == PH_CR_BLANK) begin
            phase_next       = PH_BODY;
            body_offset_next = offset_inc;
          end else begin
            if (phase == PH_CR_NOCOLON) begin
              step_out.line_event = EVENT_DROPPED;
            end else begin
              step_out.line_event = EVENT_KEPT;
              if (!conn_seen && name_good) begin
                conn_seen_next = 1'b1;
                if (close_good && value_idx == CLOSE_LEN) begin
                  verdict_next = VERDICT_CLOSE;
                end else if (alive_good && value_idx == ALIVE_LEN) begin
                  verdict_next = VERDICT_ALIVE;
                end else begin
                  verdict_next = VERDICT_OTHER;
                end
              end
            end
            phase_next      = PH_NAME;
            name_idx_next   = '0;
            name_good_next  = 1'b1;
            line_start_next = offset_inc;
          end
        end else begin
          // A lone CR ends the headers; the line it sits on becomes body.
          step_out.byte_class = CLASS_BODY;
          phase_next       = PH_BODY;
          body_offset_next = line_start;
        end
      end
      PH_BODY: begin
        step_out.byte_class = CLASS_BODY;
      end
      default: begin
        step_out.byte_class = CLASS_IGNORE;
      end
    endcase

    // Closing figures are taken from the state after this byte.
    ok   = phase_next inside {[PH_NAME:PH_BODY]};
    keep = (version_order_next == ORD_GREATER) ||
           (version_order_next == ORD_EQUAL && version_index_next >= VER_LEN);
    if (conn_seen_next && verdict_next == VERDICT_CLOSE) begin
      keep = 1'b0;
    end else if (conn_seen_next && verdict_next == VERDICT_ALIVE) begin
      keep = 1'b1;
    end
    start_sel = (phase_next == PH_BODY) ? body_offset_next : line_start_next;
    start_ext = ExtWidth'(start_sel);

    step_out.final_flag   = step_in.last_byte;
    step_out.parse_ok     = step_in.last_byte && ok;
    step_out.conn_persist = step_in.last_byte && ok && keep;
    if (step_in.last_byte && ok) begin
      step_out.body_start = (start_ext > ExtWidth'({BodyStartWidth{1'b1}})) ?
                            '1 : start_ext[BodyStartWidth-1:0];
    end else begin
      step_out.body_start = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step_en && step_in.last_byte)) begin
      phase         <= PH_METHOD;
      version_index <= '0;
      version_order <= ORD_EQUAL;
      name_idx      <= '0;
      name_good     <= 1'b1;
      value_idx     <= '0;
      close_good    <= 1'b1;
      alive_good    <= 1'b1;
      conn_seen     <= 1'b0;
      verdict       <= VERDICT_NONE;
      byte_offset   <= '0;
      line_start    <= '0;
      body_offset   <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      version_index <= version_index_next;
      version_order <= version_order_next;
      name_idx      <= name_idx_next;
      name_good     <= name_good_next;
      value_idx     <= value_idx_next;
      close_good    <= close_good_next;
      alive_good    <= alive_good_next;
      conn_seen     <= conn_seen_next;
      verdict       <= verdict_next;
      byte_offset   <= byte_offset_next;
      line_start    <= line_start_next;
      body_offset   <= body_offset_next;
    end
  end

endmodule

### src/http_request_head_parser.sv
// Result words are registered: the output register takes them, or the skid word
// while it is held. Throughput: one byte per cycle, set by the hrhp_parser state
// update, while the skid word is empty; once it is full, req_stall holds the input.
// Reset (rst, synchronous, active high) empties both buffers and puts the parser
// back at the start of a request, the same state it returns to after a last byte.
module http_request_head_parser
  import hrhp_pkg::*;
#(
  parameter int OFFSET_WIDTH = OffsetWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  hrhp_req_t req_word,
  output logic      res_valid,
  input  logic      res_stall,
  output hrhp_res_t res_word
);

  logic      accept_in;
  logic      take_out;
  logic      skid_valid;
  hrhp_res_t skid_word;
  hrhp_res_t step_word;

  // The parser state advances only on an accepted byte.
  assign req_stall = skid_valid;
  assign accept_in = req_valid && !req_stall;
  assign take_out  = res_valid && !res_stall;

  hrhp_parser #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step_en  (accept_in),
    .step_in  (req_word),
    .step_out (step_word)
  );

  // Control: the output register refills from the skid word first, then from the
  // parser. The skid word only fills when the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (take_out || !res_valid) begin
      if (skid_valid) begin
        res_word <= skid_word;
      end else if (accept_in) begin
        res_word <= step_word;
      end
    end else if (accept_in) begin
      skid_word <= step_word;
    end
  end

`ifndef SYNTHESIS
  // The skid word is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid word held while output register empty");

  // A byte accepted against a held output lands in the skid word.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (accept_in && res_valid && res_stall) |=> skid_valid)
    else $error("accepted byte not captured while output stalled");

  // Closing figures are zero except on the last result of a request.
  a_final_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_word.final_flag) |->
      (!res_word.parse_ok && !res_word.conn_persist && res_word.body_start == '0))
    else $error("closing figures set on a non-final result");

  // A connection may only be kept when the request line parsed.
  a_keep_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.conn_persist) |-> res_word.parse_ok)
    else $error("persistence flag set on a failed request");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hrhp_pkg::*;

  // Offsets in the block saturate at the top of their width.
  localparam int OFFSET_MAX = (1 << OffsetWidthDefault) - 1;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate result hold-off that backs the block up.
  localparam int HOLD_CYCLES = 64;
  // Useful (not ignored) bytes per random phase.
  localparam int PHASE_BYTES = 210;

  // This class tracks the parser state for the bytes that the block accepted, and
  // holds the tagged words that the block still owes, oldest first.
  class parse_scoreboard;
    localparam logic [79:0] VERSION_TEXT = "HTTP/1.1";
    localparam logic [79:0] CONN_TEXT    = "Connection";
    localparam logic [79:0] CLOSE_TEXT   = "close";
    localparam logic [79:0] ALIVE_TEXT   = "keep-alive";

    hrhp_phase_t   phase;
    hrhp_order_t   ver_order;
    hrhp_verdict_t verdict;
    int            ver_idx;
    int            name_idx;
    int            value_idx;
    bit            name_good;
    bit            close_good;
    bit            alive_good;
    bit            conn_seen;
    int            offset;
    int            line_start;
    int            body_at;
    hrhp_res_t     tags_due[$];
    int            errors = 0;
    int            parsed_bytes = 0;

    function void restart();
      phase      = PH_METHOD;
      ver_order  = ORD_EQUAL;
      verdict    = VERDICT_NONE;
      ver_idx    = 0;
      name_idx   = 0;
      value_idx  = 0;
      name_good  = 1'b1;
      close_good = 1'b1;
      alive_good = 1'b1;
      conn_seen  = 1'b0;
      offset     = 0;
      line_start = 0;
      body_at    = 0;
    endfunction

    function int next_offset(int v);
      return (v >= OFFSET_MAX) ? OFFSET_MAX : v + 1;
    endfunction

    function int next_index(int v);
      return (v >= 15) ? 15 : v + 1;
    endfunction

    // Character pos of a text that is len characters long.
    function logic [7:0] text_char(logic [79:0] txt, int len, int pos);
      return txt[8*(len-1-pos) +: 8];
    endfunction

    function void open_header_line();
      phase      = PH_NAME;
      name_idx   = 0;
      name_good  = 1'b1;
      line_start = next_offset(offset);
    endfunction

    function void note_byte(hrhp_req_t w);
      logic [7:0] b;
      hrhp_res_t  r;
      bit         keep;
      b = w.data_byte;
      r = '0;
      r.echo_byte  = b;
      r.byte_class = CLASS_IGNORE;
      r.line_event = EVENT_NONE;
      case (phase)
        PH_METHOD, PH_PATH: begin
          if (b == CHAR_CR) begin
            r.byte_class = CLASS_SEP;
            phase = PH_FAILED;
          end else if (b == CHAR_SP) begin
            r.byte_class = CLASS_SEP;
            phase = (phase == PH_METHOD) ? PH_PATH : PH_VERSION;
          end else begin
            r.byte_class = (phase == PH_METHOD) ? CLASS_METHOD : CLASS_PATH;
          end
        end
        PH_VERSION: begin
          if (b == CHAR_CR) begin
            r.byte_class = CLASS_SEP;
            phase = PH_RL_CR;
          end else begin
            r.byte_class = CLASS_VER;
            if (ver_order == ORD_EQUAL) begin
              if (ver_idx >= 8) ver_order = ORD_GREATER;
              else if (b < text_char(VERSION_TEXT, 8, ver_idx)) ver_order = ORD_LESS;
              else if (b > text_char(VERSION_TEXT, 8, ver_idx)) ver_order = ORD_GREATER;
            end
            ver_idx = next_index(ver_idx);
          end
        end
        PH_RL_CR: begin
          if (b == CHAR_LF) begin
            r.byte_class = CLASS_SEP;
            open_header_line();
          end else begin
            phase = PH_FAILED;
          end
        end
        PH_NAME: begin
          if (b == CHAR_CR) begin
            r.byte_class = CLASS_SEP;
            phase = (name_idx == 0) ? PH_CR_BLANK : PH_CR_NOCOLON;
          end else if (b == CHAR_COLON) begin
            r.byte_class = CLASS_SEP;
            name_good  = name_good && (name_idx == 10);
            phase      = PH_VALUE;
            value_idx  = 0;
            close_good = 1'b1;
            alive_good = 1'b1;
          end else begin
            r.byte_class = CLASS_NAME;
            if (name_idx >= 10 || b != text_char(CONN_TEXT, 10, name_idx)) name_good = 1'b0;
            name_idx = next_index(name_idx);
          end
        end
        PH_VALUE: begin
          if (b == CHAR_CR) begin
            r.byte_class = CLASS_SEP;
            phase = PH_CR_COLON;
          end else begin
            r.byte_class = CLASS_VALUE;
            if (!(value_idx == 0 && (b == CHAR_SP || b == CHAR_TAB))) begin
              if (value_idx >= 5 || b != text_char(CLOSE_TEXT, 5, value_idx)) close_good = 1'b0;
              if (value_idx >= 10 || b != text_char(ALIVE_TEXT, 10, value_idx)) alive_good = 1'b0;
              value_idx = next_index(value_idx);
            end
          end
        end
        PH_CR_BLANK, PH_CR_NOCOLON, PH_CR_COLON: begin
          if (b == CHAR_LF) begin
            r.byte_class = CLASS_SEP;
            if (phase == PH_CR_BLANK) begin
              phase   = PH_BODY;
              body_at = next_offset(offset);
            end else begin
              if (phase == PH_CR_NOCOLON) begin
                r.line_event = EVENT_DROPPED;
              end else begin
                r.line_event = EVENT_KEPT;
                if (!conn_seen && name_good) begin
                  conn_seen = 1'b1;
                  if (close_good && value_idx == 5) verdict = VERDICT_CLOSE;
                  else if (alive_good && value_idx == 10) verdict = VERDICT_ALIVE;
                  else verdict = VERDICT_OTHER;
                end
              end
              open_header_line();
            end
          end else begin
            r.byte_class = CLASS_BODY;
            phase   = PH_BODY;
            body_at = line_start;
          end
        end
        PH_BODY: begin
          r.byte_class = CLASS_BODY;
        end
        default: begin
          r.byte_class = CLASS_IGNORE;
        end
      endcase
      offset = next_offset(offset);
      if (r.byte_class != CLASS_IGNORE) parsed_bytes++;
      if (w.last_byte) begin
        r.final_flag = 1'b1;
        if (phase >= PH_NAME && phase <= PH_BODY) begin
          keep = (ver_order == ORD_GREATER) || (ver_order == ORD_EQUAL && ver_idx >= 8);
          if (conn_seen && verdict == VERDICT_CLOSE) keep = 1'b0;
          else if (conn_seen && verdict == VERDICT_ALIVE) keep = 1'b1;
          r.parse_ok     = 1'b1;
          r.conn_persist = keep;
          r.body_start   = BodyStartWidth'((phase == PH_BODY) ? body_at : line_start);
        end
        restart();
      end
      tags_due.push_back(r);
    endfunction

    function string describe(hrhp_res_t t);
      return $sformatf("byte %02h class %0d event %0d final %0b ok %0b keep %0b start %0d",
                       t.echo_byte, t.byte_class, t.line_event, t.final_flag,
                       t.parse_ok, t.conn_persist, t.body_start);
    endfunction

    function void check_word(hrhp_res_t got);
      hrhp_res_t want;
      bit        bad;
      if (tags_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %s", describe(got));
        return;
      end
      want = tags_due.pop_front();
      bad = (got.echo_byte !== want.echo_byte) || (got.byte_class !== want.byte_class) ||
            (got.line_event !== want.line_event) || (got.final_flag !== want.final_flag) ||
            (got.parse_ok !== want.parse_ok) || (got.conn_persist !== want.conn_persist) ||
            (got.body_start !== want.body_start);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch");
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  hrhp_req_t req_word;
  logic      res_valid;
  logic      res_stall;
  hrhp_res_t res_word;

  parse_scoreboard sb;

  // Bytes of the request being assembled, sent in order with the last one marked.
  logic [7:0] req_bytes[$];

  // Percent of cycles in which each side idles; the stimulus changes them per phase.
  int  send_idle_pct = 37;
  int  recv_idle_pct = 51;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit  hold_wanted = 1'b0;
  int  quiet_cycles = 0;

  http_request_head_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog counts cycles in which no word moves on either channel. A correct
  // block never goes quiet for long, since the longest hold-off is far shorter.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side. Stall is chosen at the falling edge, and a word counts as taken
  // when valid is seen high and stall low at the next rising edge. The long
  // hold-off is counted here, so the sender keeps offering bytes meanwhile and the
  // block has to fill its buffers and push back on its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      @(posedge clk);
      if (res_valid && !res_stall) sb.check_word(res_word);
    end
  end

  // Offers one word, called and returning at a falling edge. Idle cycles are decided
  // before valid goes up, so valid never reacts to stall, and once offered the word
  // holds still until it is taken. Valid is left high on return, so back-to-back
  // words never lower and raise it within one time step.
  task automatic send_word(input hrhp_req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_byte(w);
    @(negedge clk);
  endtask

  task automatic send_request();
    hrhp_req_t w;
    for (int i = 0; i < req_bytes.size(); i++) begin
      w.data_byte = req_bytes[i];
      w.last_byte = (i == req_bytes.size() - 1);
      send_word(w);
    end
    req_bytes.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    req_bytes.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endfunction

  function automatic void add_line(string s);
    add_text(s);
    add_crlf();
  endfunction

  // Random byte that leans toward the characters the parser reacts to.
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(7))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return CHAR_SP;
      3: return CHAR_COLON;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_letters(int lo, int hi);
    repeat ($urandom_range(hi, lo)) add_byte(8'($urandom_range(8'h7A, 8'h61)));
  endfunction

  // Versions around HTTP/1.1 so that every ordering outcome turns up.
  function automatic void add_version();
    case ($urandom_range(9))
      0, 1: add_text("HTTP/1.1");
      2: add_text("HTTP/1.0");
      3: add_text("HTTP/2");
      4: add_text("HTTP/1.10");
      5: add_text("HTTP/1");
      6: add_text("HTTP/1.1 extra-version-text");
      7: add_text("HTTP/0.9");
      default: repeat ($urandom_range(6, 0)) add_byte(8'($urandom_range(8'h7E, 8'h20)));
    endcase
  endfunction

  function automatic void add_name();
    case ($urandom_range(9))
      0, 1, 2: add_text("Connection");
      3: add_text("connection");
      4: add_text("Connectio");
      5: add_text("Connections");
      6: add_text("Host");
      7: ;
      default: add_letters(1, 18);
    endcase
  endfunction

  function automatic void add_value();
    repeat ($urandom_range(2)) add_byte($urandom_range(1) ? CHAR_SP : CHAR_TAB);
    case ($urandom_range(9))
      0, 1: add_text("close");
      2, 3: add_text("keep-alive");
      4: add_text("closed");
      5: add_text("keep-alive2");
      6: add_text("Close");
      7: ;
      default: repeat ($urandom_range(18, 0)) add_byte(8'($urandom_range(8'h7E, 8'h20)));
    endcase
  endfunction

  // Mostly well formed requests with random content; the rest is noise, requests
  // cut short at a random byte, and requests with one byte overwritten.
  function automatic void build_random_request();
    int shape;
    int cut;
    shape = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(12, 1)) add_byte(noisy_byte());
      return;
    end
    add_byte(8'($urandom_range(8'h5A, 8'h41)));
    repeat ($urandom_range(3)) add_byte(8'($urandom_range(8'h5A, 8'h41)));
    add_byte(CHAR_SP);
    add_text("/");
    repeat ($urandom_range(4)) add_byte(8'($urandom_range(8'h7E, 8'h21)));
    add_byte(CHAR_SP);
    add_version();
    add_crlf();
    repeat ($urandom_range(3)) begin
      add_name();
      if ($urandom_range(9) != 0) begin
        add_byte(CHAR_COLON);
        add_value();
      end
      add_crlf();
    end
    add_crlf();
    repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
    if (shape < 22) begin
      cut = $urandom_range(req_bytes.size(), 1);
      while (req_bytes.size() > cut) void'(req_bytes.pop_back());
    end else if (shape < 30) begin
      req_bytes[$urandom_range(req_bytes.size() - 1)] = noisy_byte();
    end
  endfunction

  task automatic run_random(input int useful);
    int goal;
    goal = sb.parsed_bytes + useful;
    while (sb.parsed_bytes < goal) begin
      build_random_request();
      send_request();
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req_word  = '0;
    res_stall = 1'b0;
    sb = new;
    sb.restart();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests, sent with the first idling mix: sender idles less than
    // the receiver.
    // Plain request with an empty header block and no body.
    add_line("GET / HTTP/1.1");
    add_crlf();
    send_request();
    // Only the first Connection header counts; an older version is kept alive.
    add_line("GET /a HTTP/1.0");
    add_line("Connection: keep-alive");
    add_line("Connection: close");
    add_crlf();
    add_text("hi");
    send_request();
    // Close without a blank, a second header, a dropped line, and extreme bytes.
    add_line("POST /x HTTP/1.1");
    add_line("Connection:close");
    add_line("Host: a");
    add_line("NoColon");
    add_crlf();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_request();
    // Leading blanks of both kinds before a value that is neither token.
    add_line("GET / HTTP/1.1");
    add_line("Connection: \t upgrade");
    add_crlf();
    send_request();
    // CR before the second space fails the request, the rest is ignored.
    add_text("GET /");
    add_byte(CHAR_CR);
    add_text("xy");
    send_request();
    // CR without LF at the end of the request line.
    add_text("GET / HTTP/1.1");
    add_byte(CHAR_CR);
    add_text("X");
    send_request();
    // Same, with the CR as the final byte.
    add_text("GET / HTTP/1.1");
    add_byte(CHAR_CR);
    send_request();
    // Data ends in the method.
    add_text("GET");
    send_request();
    // Header CR without LF starts the body at the start of that line.
    add_line("GET / HTTP/1.1");
    add_text("Host: a");
    add_byte(CHAR_CR);
    add_text("body");
    send_request();
    // Header CR as the final byte.
    add_line("GET / HTTP/1.1");
    add_text("Host: a");
    add_byte(CHAR_CR);
    send_request();
    // Data ends inside a header line.
    add_line("GET / HTTP/1.1");
    add_text("Host: ab");
    send_request();
    // Data ends right after the request line, so the body is empty.
    add_line("GET / HTTP/1.1");
    send_request();
    // A lone CR on an empty line followed by a body byte.
    add_line("GET / HTTP/1.1");
    add_byte(CHAR_CR);
    add_text("Z");
    send_request();
    // Long version, name and value drive every match index into saturation.
    add_line("GET / HTTP/1.1 trailing-version-text");
    add_line("ConnectionConnectionX: keep-alive-keep-alive-x");
    add_line("Connection:\tkeep-alive");
    add_crlf();
    send_request();
    // A header keeps alive an old version; a newer version alone does too.
    add_line("GET / HTTP/0.9");
    add_line("Connection: keep-alive");
    add_crlf();
    send_request();
    add_line("GET / HTTP/2");
    add_line(": no name");
    add_crlf();
    send_request();
    // Single byte requests, and one that stops in the version.
    add_byte(8'hFF);
    send_request();
    add_byte(8'h00);
    send_request();
    add_text("A  ");
    send_request();

    // Random phase one, with one long hold-off on the result side at its start.
    hold_wanted = 1'b1;
    run_random(PHASE_BYTES);

    // Random phase two: the receiver now idles less than the sender.
    send_idle_pct = 51;
    recv_idle_pct = 37;
    run_random(PHASE_BYTES);

    // Random phase three at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_BYTES);
    req_valid <= 1'b0;

    // Wait for every owed word, then a few cycles for anything stray.
    while (sb.tags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.tags_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
